// ----- hw/rtl/wstc_pkg.sv -----
// Shared types, constants and helpers for the work-steal tempo chain.
package wstc_pkg;

    localparam int WORKERS    = 16;
    localparam int IDX_W      = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int WALK_LIMIT = 16;
    localparam int CNT_W      = (WALK_LIMIT > 1) ? $clog2(WALK_LIMIT) : 1;
    localparam int ID_W       = 4;
    localparam int TEMPO_W    = 4;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [TEMPO_W-1:0] TOP_RESET = TEMPO_W'(2);

    // register index as taken from paddr
    typedef enum logic {
        REG_TOP_TEMPO = 1'b0,
        REG_NONE      = 1'b1
    } t_reg_idx;

    typedef enum logic {
        CMD_STEAL = 1'b0,
        CMD_RELAY = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd            cmd;
        logic [ID_W-1:0] worker;
        logic [ID_W-1:0] victim;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0]    worker_id;
        logic [TEMPO_W-1:0] new_tempo;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] idx;
    } t_link;

    localparam t_link NO_LINK = '{vld: 1'b0, idx: '0};

    function automatic logic in_range(input logic [ID_W-1:0] f);
        in_range = (32'(f) < WORKERS);
    endfunction

    function automatic logic [IDX_W-1:0] to_idx(input logic [ID_W-1:0] f);
        to_idx = IDX_W'(f);
    endfunction

endpackage

// ----- hw/rtl/wstc_tempo_alu.sv -----
// Shared tempo unit: raise capped at the top level, or lower floored at 1.
module wstc_tempo_alu (
    input  wstc_pkg::t_cmd                     i_op,
    input  logic [wstc_pkg::TEMPO_W-1:0]       i_tempo,
    input  logic [wstc_pkg::TEMPO_W-1:0]       i_top,
    output logic [wstc_pkg::TEMPO_W-1:0]       o_tempo
);

    logic [wstc_pkg::TEMPO_W-1:0] eff_top;
    logic [wstc_pkg::TEMPO_W:0]   sum;

    assign eff_top = (i_top == '0) ? wstc_pkg::TEMPO_W'(1) : i_top;
    assign sum     = {1'b0, i_tempo} + (wstc_pkg::TEMPO_W+1)'(1);

    always_comb begin
        case (i_op)
            wstc_pkg::CMD_RELAY: begin
                o_tempo = (sum > {1'b0, eff_top}) ? eff_top : sum[wstc_pkg::TEMPO_W-1:0];
            end
            wstc_pkg::CMD_STEAL: begin
                o_tempo = (i_tempo > wstc_pkg::TEMPO_W'(2)) ?
                          i_tempo - wstc_pkg::TEMPO_W'(1) : wstc_pkg::TEMPO_W'(1);
            end
            default: begin
                o_tempo = i_tempo;
            end
        endcase
    end

endmodule

// ----- hw/rtl/wstc_cfg.sv -----
// APB register block holding the top tempo level.
module wstc_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wstc_pkg::ADDR_W-1:0]         paddr,
    input  logic [wstc_pkg::DATA_W-1:0]         pwdata,
    output logic [wstc_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    output logic [wstc_pkg::TEMPO_W-1:0]        o_top
);

    logic [wstc_pkg::TEMPO_W-1:0] r_top;
    wstc_pkg::t_reg_idx           reg_idx;

    assign reg_idx = wstc_pkg::t_reg_idx'(paddr[2]);
    assign pready  = 1'b1;
    assign o_top   = r_top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= wstc_pkg::TOP_RESET;
        end else if (psel && penable && pwrite && reg_idx == wstc_pkg::REG_TOP_TEMPO) begin
            r_top <= pwdata[wstc_pkg::TEMPO_W-1:0];
        end
    end

    always_comb begin
        case (reg_idx)
            wstc_pkg::REG_TOP_TEMPO: prdata = wstc_pkg::DATA_W'(r_top);
            default:                 prdata = '0;
        endcase
    end

endmodule

// ----- hw/rtl/work_steal_tempo_chain.sv -----
// Top level: tempo scheduler for work-stealing workers with a linked steal chain.
//
// A command is taken when start is high and busy is low; busy then stays high
// until the command is finished. A steal keeps busy through the start state
// alone and its single result strobes on o_res_valid in the cycle after. A
// relay keeps busy through the start state, the walk over the successors (the
// walk state is entered even with no successor, at most 16 raises) and the
// unlink state, and its results come out one per cycle in chain order, back to
// back, the final one flagged by last. The walk visits one chain entry per
// cycle through the shared tempo unit and the single read port on each link
// table. Results are strobed for exactly one cycle and must be taken as they
// appear; there is no stall on that side. top_tempo is written over APB and
// should only be changed while busy is low.
module work_steal_tempo_chain (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  wstc_pkg::t_in_item                  i_item,
    output logic                                o_res_valid,
    output wstc_pkg::t_out_item                 o_result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wstc_pkg::ADDR_W-1:0]         paddr,
    input  logic [wstc_pkg::DATA_W-1:0]         pwdata,
    output logic [wstc_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_WALK,
        S_UNLINK
    } t_state;

    t_state r_state;

    // latched command
    wstc_pkg::t_cmd                   r_cmd;
    logic                             r_w_ok;
    logic                             r_v_ok;
    logic [wstc_pkg::IDX_W-1:0]       r_w;
    logic [wstc_pkg::IDX_W-1:0]       r_v;

    // walk cursor and raise count
    wstc_pkg::t_link                  r_cur;
    logic [wstc_pkg::CNT_W-1:0]       r_cnt;

    // per-worker state
    logic [wstc_pkg::TEMPO_W-1:0]     r_tempo [wstc_pkg::WORKERS];
    wstc_pkg::t_link                  r_next  [wstc_pkg::WORKERS];
    wstc_pkg::t_link                  r_prev  [wstc_pkg::WORKERS];

    logic                             r_res_valid;
    wstc_pkg::t_out_item              r_res;

    logic [wstc_pkg::TEMPO_W-1:0]     top;
    logic [wstc_pkg::IDX_W-1:0]       tempo_addr;
    logic [wstc_pkg::IDX_W-1:0]       next_addr;
    logic [wstc_pkg::TEMPO_W-1:0]     tempo_rd;
    wstc_pkg::t_link                  next_rd;
    wstc_pkg::t_link                  prev_rd;
    logic [wstc_pkg::TEMPO_W-1:0]     alu_out;
    logic                             walk_last;

    wstc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_top   (top)
    );

    // One read address per table per cycle. Tempo: the cursor in the walk, else
    // the victim. Successor: the cursor too, a steal's victim, else the worker.
    assign tempo_addr = (r_state == S_WALK) ? r_cur.idx : r_v;
    always_comb begin
        case (r_state)
            S_WALK:  next_addr = r_cur.idx;
            S_START: next_addr = (r_cmd == wstc_pkg::CMD_STEAL) ? r_v : r_w;
            default: next_addr = r_w;
        endcase
    end

    assign tempo_rd = r_tempo[tempo_addr];
    assign next_rd  = r_next[next_addr];
    assign prev_rd  = r_prev[r_w];

    // steal lowers, relay raises
    wstc_tempo_alu u_alu (
        .i_op    (r_cmd),
        .i_tempo (tempo_rd),
        .i_top   (top),
        .o_tempo (alu_out)
    );

    // final raise: end of chain or walk limit reached
    assign walk_last = !next_rd.vld || (r_cnt == wstc_pkg::CNT_W'(wstc_pkg::WALK_LIMIT - 1));

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_result    = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
            for (int i = 0; i < wstc_pkg::WORKERS; i++) begin
                r_tempo[i] <= wstc_pkg::TOP_RESET;
                r_next[i]  <= wstc_pkg::NO_LINK;
                r_prev[i]  <= wstc_pkg::NO_LINK;
            end
        end else begin
            r_res_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd   <= i_item.cmd;
                        r_w_ok  <= wstc_pkg::in_range(i_item.worker);
                        r_v_ok  <= wstc_pkg::in_range(i_item.victim);
                        r_w     <= wstc_pkg::to_idx(i_item.worker);
                        r_v     <= wstc_pkg::to_idx(i_item.victim);
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    if (!r_w_ok || (r_cmd == wstc_pkg::CMD_STEAL && !r_v_ok)) begin
                        // out-of-range index: dropped without a result
                        r_state <= S_IDLE;
                    end else if (r_cmd == wstc_pkg::CMD_STEAL) begin
                        r_tempo[r_w] <= alu_out;
                        if (r_w != r_v) begin
                            // thief slots in after the victim; later writes win
                            if (next_rd.vld) begin
                                r_next[r_w]         <= next_rd;
                                r_prev[next_rd.idx] <= '{vld: 1'b1, idx: r_w};
                            end
                            r_next[r_v] <= '{vld: 1'b1, idx: r_w};
                            r_prev[r_w] <= '{vld: 1'b1, idx: r_v};
                        end
                        r_res_valid <= 1'b1;
                        r_res       <= '{worker_id: wstc_pkg::ID_W'(r_w),
                                         new_tempo: alu_out, last: 1'b1};
                        r_state     <= S_IDLE;
                    end else begin
                        r_cur   <= next_rd;
                        r_cnt   <= '0;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (!r_cur.vld) begin
                        r_state <= S_UNLINK;
                    end else begin
                        r_tempo[r_cur.idx] <= alu_out;
                        r_res_valid        <= 1'b1;
                        r_res              <= '{worker_id: wstc_pkg::ID_W'(r_cur.idx),
                                                new_tempo: alu_out, last: walk_last};
                        r_cnt              <= r_cnt + wstc_pkg::CNT_W'(1);
                        r_cur              <= next_rd;
                        if (walk_last) begin
                            r_state <= S_UNLINK;
                        end
                    end
                end
                S_UNLINK: begin
                    // join neighbours, then clear own links (own clear wins)
                    if (prev_rd.vld) begin
                        r_next[prev_rd.idx] <= next_rd;
                    end
                    if (next_rd.vld) begin
                        r_prev[next_rd.idx] <= prev_rd;
                    end
                    r_next[r_w] <= wstc_pkg::NO_LINK;
                    r_prev[r_w] <= wstc_pkg::NO_LINK;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/wstc_checker.sv -----
// Port-level checks for the tempo chain, bound to the top level.
module wstc_checker (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic                    o_res_valid,
    input  wstc_pkg::t_out_item     o_result
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after a command transfer");

    a_burst_unbroken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_result.last |=> o_res_valid)
        else $error("result burst broken before last");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_result.last |=> !o_res_valid)
        else $error("result strobe straight after last");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid && !busy)
        else $error("outputs active after reset");

endmodule

bind work_steal_tempo_chain wstc_checker u_wstc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_res_valid (o_res_valid),
    .o_result    (o_result)
);

// ----- sim/work_steal_tempo_chain_test.sv -----
// Testbench for the work-steal tempo chain: command stream, APB set-up and result checks.
`timescale 1ns / 1ps

module work_steal_tempo_chain_test;
    import wstc_pkg::*;

    // Mirror of the tempo table and both link tables. Each accepted command is
    // replayed here and the tempo reports it should cause are queued in order.
    class tempo_ledger;
        t_out_item          due_tempos[$];
        logic [TEMPO_W-1:0] top;
        logic [TEMPO_W-1:0] tempo[WORKERS];
        t_link              succ[WORKERS];
        t_link              pred[WORKERS];
        int                 errors;

        function new();
            errors = 0;
            top    = TOP_RESET;
            for (int i = 0; i < WORKERS; i++) begin
                tempo[i] = TOP_RESET;
                succ[i]  = NO_LINK;
                pred[i]  = NO_LINK;
            end
        endfunction

        function void set_top(logic [DATA_W-1:0] val);
            top = val[TEMPO_W-1:0];
        endfunction

        function int pending();
            return due_tempos.size();
        endfunction

        function void apply_command(t_in_item it);
            int                 w;
            int                 v;
            int                 n;
            logic [TEMPO_W-1:0] cap;
            logic [TEMPO_W:0]   raised;
            t_link              cur;
            t_link              p;
            t_link              s;
            t_out_item          held;
            bit                 have_held;
            w = int'(it.worker);
            v = int'(it.victim);
            if (w >= WORKERS)
                return;
            if (it.cmd == CMD_STEAL) begin
                if (v >= WORKERS)
                    return;
                tempo[w] = (tempo[v] > 2) ? tempo[v] - 1'b1 : TEMPO_W'(1);
                // self steal only touches the tempo
                if (w != v) begin
                    s = succ[v];
                    if (s.vld) begin
                        succ[w]     = s;
                        pred[s.idx] = '{vld: 1'b1, idx: IDX_W'(w)};
                    end
                    succ[v] = '{vld: 1'b1, idx: IDX_W'(w)};
                    pred[w] = '{vld: 1'b1, idx: IDX_W'(v)};
                end
                due_tempos.push_back('{worker_id: ID_W'(w), new_tempo: tempo[w], last: 1'b1});
            end else begin
                cap       = (top == 0) ? TEMPO_W'(1) : top;
                cur       = succ[w];
                n         = 0;
                have_held = 0;
                // walk is bounded so that a looped chain ends
                while (cur.vld && n < WALK_LIMIT) begin
                    raised         = {1'b0, tempo[cur.idx]} + 1'b1;
                    tempo[cur.idx] = (raised > {1'b0, cap}) ? cap : raised[TEMPO_W-1:0];
                    if (have_held)
                        due_tempos.push_back(held);
                    held      = '{worker_id: ID_W'(cur.idx), new_tempo: tempo[cur.idx],
                                  last: 1'b0};
                    have_held = 1;
                    n++;
                    cur = succ[cur.idx];
                end
                if (have_held) begin
                    held.last = 1'b1;
                    due_tempos.push_back(held);
                end
                p = pred[w];
                s = succ[w];
                if (p.vld)
                    succ[p.idx] = s;
                if (s.vld)
                    pred[s.idx] = p;
                succ[w] = NO_LINK;
                pred[w] = NO_LINK;
            end
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (due_tempos.size() == 0) begin
                report_mismatch($sformatf("unexpected result worker %0d tempo %0d last %0d",
                                          got.worker_id, got.new_tempo, got.last));
                return;
            end
            want = due_tempos.pop_front();
            if (got.worker_id !== want.worker_id)
                report_mismatch($sformatf("worker_id %0d, want %0d",
                                          got.worker_id, want.worker_id));
            if (got.new_tempo !== want.new_tempo)
                report_mismatch($sformatf("new_tempo %0d, want %0d (worker %0d)",
                                          got.new_tempo, want.new_tempo, want.worker_id));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %0d, want %0d (worker %0d)",
                                          got.last, want.last, want.worker_id));
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    t_in_item            i_item;
    logic                o_res_valid;
    t_out_item           o_result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    tempo_ledger ledger = new();

    work_steal_tempo_chain i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_res_valid (o_res_valid),
        .o_result    (o_result),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Results cannot be held off, so every strobe is a transfer.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_res_valid === 1'b1)
            ledger.check_result(o_result);
    end

    // Hold the command until a rising edge sees busy low; that edge is the transfer.
    task issue_command(t_cmd c, int w, int v);
        @(negedge i_clk);
        start  = 1'b1;
        i_item = '{cmd: c, worker: ID_W'(w), victim: ID_W'(v)};
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        ledger.apply_command(i_item);
    endtask

    task pause_sender(int cycles);
        @(negedge i_clk);
        start = 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Drain: all reports in, block idle, then a margin for a relay that walks
    // nothing and so leaves no result behind it.
    task settle();
        @(negedge i_clk);
        start = 1'b0;
        while (ledger.pending() != 0 || busy !== 1'b0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access until pready.
    task write_top(logic [DATA_W-1:0] val);
        settle();
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'(4 * int'(REG_TOP_TEMPO));
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do
            @(posedge i_clk);
        while (pready !== 1'b1);
        ledger.set_top(val);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        logic [DATA_W-1:0] phase_top[6];
        int                w;
        int                v;
        t_cmd              c;

        start   = 1'b0;
        i_item  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // --- directed part, top at its reset value ---
        issue_command(CMD_STEAL, 1, 0);                   // victim at 2, thief floors at 1
        issue_command(CMD_STEAL, 2, 0);                   // inserted ahead of old successor
        issue_command(CMD_STEAL, 3, 2);
        issue_command(CMD_RELAY, 0, 15);                  // walks 2, 3, 1
        issue_command(CMD_STEAL, 5, 5);                   // self steal
        issue_command(CMD_RELAY, 7, 0);                   // no successor, no result
        issue_command(CMD_STEAL, 15, 14);
        issue_command(CMD_STEAL, 0, 15);
        issue_command(CMD_STEAL, 4, 6);
        issue_command(CMD_STEAL, 6, 4);                   // 4 and 6 now form a loop
        issue_command(CMD_RELAY, 6, 9);                   // walk cut short; 4 left self-looped

        // raise to the top of the range
        write_top(32'd15);
        issue_command(CMD_RELAY, 4, 3);                   // sixteen raises of 4, capped at 15
        issue_command(CMD_STEAL, 10, 4);                  // 14 from a victim at 15
        issue_command(CMD_STEAL, 11, 10);
        issue_command(CMD_STEAL, 4, 10);

        // zero acts as one: tempos above the new top drop to it
        write_top(32'd0);
        issue_command(CMD_RELAY, 10, 12);
        issue_command(CMD_RELAY, 4, 0);
        write_top(32'd1);
        issue_command(CMD_STEAL, 12, 11);
        issue_command(CMD_RELAY, 11, 5);

        // --- random part: six phases under a range of top settings ---
        phase_top[0] = 32'd3;
        phase_top[1] = 32'd15;
        phase_top[2] = 32'd1;
        phase_top[3] = $urandom_range(2, 14);
        phase_top[4] = 32'd0;
        phase_top[5] = {16'($urandom_range(0, 'hFFFF)), 12'h000,
                        4'($urandom_range(1, 15))};
        for (int ph = 0; ph < 6; ph++) begin
            write_top(phase_top[ph]);
            for (int k = 0; k < 60; k++) begin
                // half the commands confine themselves to a few workers, so
                // chains grow deep and loop back on themselves
                if ($urandom_range(99) < 50) begin
                    w = $urandom_range(0, 5);
                    v = $urandom_range(0, 5);
                end else begin
                    w = $urandom_range(0, WORKERS - 1);
                    v = $urandom_range(0, WORKERS - 1);
                end
                c = ($urandom_range(99) < 62) ? CMD_STEAL : CMD_RELAY;
                issue_command(c, w, v);
                // phase 2 runs without sender gaps; phase 3 drains once midway
                if (ph == 3 && k == 30)
                    settle();
                else if (ph != 2 && $urandom_range(99) < 7)
                    pause_sender($urandom_range(1, 6));
            end
        end

        settle();
        if (ledger.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/wstc_pkg.sv
hw/rtl/wstc_tempo_alu.sv
hw/rtl/wstc_cfg.sv
hw/rtl/work_steal_tempo_chain.sv
hw/rtl/wstc_checker.sv
sim/work_steal_tempo_chain_test.sv
